// File: sv/ultrasonic_ranger_controller_assert.svh
// Assertion macros for the ultrasonic ranger controller checker.
// Depends on nothing; the including scope must provide clk and rst_n.
`ifndef ULTRASONIC_RANGER_CONTROLLER_ASSERT_SVH
`define ULTRASONIC_RANGER_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define URC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("urc checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define URC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("urc checker: next-cycle property failed");

`endif

// File: sv/urc_pkg.sv
// Shared types and constants of the ultrasonic ranger controller.
// Depends on nothing; the sequencer, distance stage, top and checker import it.
package urc_pkg;

    localparam int TRIGGER_TICKS = 10;
    localparam int PRE_LOW_TICKS = 2;
    localparam int DURATION_BITS = 24;
    localparam int STEP_BITS     = 10;
    localparam int CM_BITS       = 19;
    localparam int IN_BITS       = 17;
    localparam int PHASE_BITS    = 3;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 10;

    localparam logic [STEP_BITS-1:0] BREATH_RESET = STEP_BITS'(50);
    localparam logic [DURATION_BITS-1:0] DUR_MAX = {DURATION_BITS{1'b1}};

    // Distance by reciprocal: cm = ((d >> 1) * CM_RECIP) >> CM_SHIFT (divide by 2*29),
    // in = ((d >> 2) * IN_RECIP) >> IN_SHIFT (divide by 4*37). Exact for 24-bit d.
    localparam int CM_RECIP_BITS = 24;
    localparam int IN_RECIP_BITS = 25;
    localparam logic [CM_RECIP_BITS-1:0] CM_RECIP = CM_RECIP_BITS'(9256396);
    localparam logic [IN_RECIP_BITS-1:0] IN_RECIP = IN_RECIP_BITS'(29020050);
    localparam int CM_SHIFT = 28;
    localparam int IN_SHIFT = 30;
    localparam int CM_PROD_BITS = DURATION_BITS - 1 + CM_RECIP_BITS;
    localparam int IN_PROD_BITS = DURATION_BITS - 2 + IN_RECIP_BITS;

    typedef enum logic [PHASE_BITS-1:0] {
        PH_IDLE   = 3'd0,
        PH_PRELOW = 3'd1,
        PH_TRIG   = 3'd2,
        PH_WAIT   = 3'd3,
        PH_MEAS   = 3'd4,
        PH_REST   = 3'd5
    } phase_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ENABLE       = 2'd0,
        REG_ACTIVE_LEVEL = 2'd1,
        REG_SHARED_PIN   = 2'd2,
        REG_BREATH       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic                 enable;
        logic                 echo_active_level;
        logic                 shared_pin;
        logic [STEP_BITS-1:0] breath_ticks;
    } urc_cfg_t;

    // One processed tick on its way from the sequencer to the distance stage.
    typedef struct packed {
        logic                     trigger_level;
        logic                     trigger_drive;
        logic                     measure_done;
        phase_t                   phase;
        logic [DURATION_BITS-1:0] duration;
    } urc_meas_t;

    typedef struct packed {
        logic                     trigger_level;
        logic                     trigger_drive;
        logic                     measure_done;
        logic [DURATION_BITS-1:0] duration_us;
        logic [CM_BITS-1:0]       distance_cm;
        logic [IN_BITS-1:0]       distance_in;
        logic [PHASE_BITS-1:0]    phase;
    } urc_result_t;

endpackage

// File: sv/urc_echo_if.sv
// Input channel of the ultrasonic ranger controller: one echo sample per item.
// Depends on nothing.
interface urc_echo_if;
    logic valid;
    logic ready;
    logic echo_level;

    modport source (output valid, output echo_level, input ready);
    modport sink (input valid, input echo_level, output ready);
endinterface

// File: sv/urc_result_if.sv
// Output channel of the ultrasonic ranger controller: one result per tick item.
// Depends on urc_pkg for the field widths.
interface urc_result_if;
    logic                              valid;
    logic                              ready;
    logic                              trigger_level;
    logic                              trigger_drive;
    logic                              measure_done;
    logic [urc_pkg::DURATION_BITS-1:0] duration_us;
    logic [urc_pkg::CM_BITS-1:0]       distance_cm;
    logic [urc_pkg::IN_BITS-1:0]       distance_in;
    logic [urc_pkg::PHASE_BITS-1:0]    phase;

    modport source (output valid, output trigger_level, output trigger_drive,
                    output measure_done, output duration_us, output distance_cm,
                    output distance_in, output phase, input ready);
    modport sink (input valid, input trigger_level, input trigger_drive,
                  input measure_done, input duration_us, input distance_cm,
                  input distance_in, input phase, output ready);
endinterface

// File: sv/urc_sequencer.sv
// Ranging sequencer: phase, step and pulse counters, latched duration.
// Depends on urc_pkg.
module urc_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  logic              echo_level,
    input  urc_pkg::urc_cfg_t cfg,
    output logic              meas_valid,
    output urc_pkg::urc_meas_t meas
);
    import urc_pkg::*;

    phase_t                   phase_reg, phase_next;
    logic [STEP_BITS-1:0]     step_reg, step_next;
    logic [DURATION_BITS-1:0] pulse_reg, pulse_next;
    logic [DURATION_BITS-1:0] last_dur_reg, last_dur_next;
    logic                     valid_reg;
    urc_meas_t                meas_reg, meas_next;

    phase_t                   ph;
    logic [STEP_BITS-1:0]     step_cur;
    logic [DURATION_BITS-1:0] pulse_cur;
    logic [STEP_BITS:0]       step_inc;
    logic                     active;
    phase_t                   first_phase;

    logic accept;
    assign accept = advance && in_valid;

    always_comb
    begin
        // A disabled tick aborts the cycle before it is processed.
        ph        = cfg.enable ? phase_reg : PH_IDLE;
        step_cur  = cfg.enable ? step_reg : '0;
        pulse_cur = cfg.enable ? pulse_reg : '0;
        step_inc  = {1'b0, step_cur} + (STEP_BITS+1)'(1);
        active    = (echo_level == cfg.echo_active_level);
        first_phase = cfg.shared_pin ? PH_PRELOW : PH_TRIG;

        phase_next    = ph;
        step_next     = step_cur;
        pulse_next    = pulse_cur;
        last_dur_next = last_dur_reg;
        meas_next.trigger_level = 1'b0;
        meas_next.trigger_drive = 1'b1;
        meas_next.measure_done  = 1'b0;
        meas_next.phase         = ph;

        unique case (ph)
            PH_PRELOW:
            begin
                if (step_inc >= (STEP_BITS+1)'(PRE_LOW_TICKS))
                begin
                    phase_next = PH_TRIG;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_inc[STEP_BITS-1:0];
                end
            end
            PH_TRIG:
            begin
                meas_next.trigger_level = 1'b1;
                if (step_inc >= (STEP_BITS+1)'(TRIGGER_TICKS))
                begin
                    phase_next = PH_WAIT;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_inc[STEP_BITS-1:0];
                end
            end
            PH_WAIT:
            begin
                meas_next.trigger_drive = !cfg.shared_pin;
                if (active)
                begin
                    pulse_next = DURATION_BITS'(1);
                    phase_next = PH_MEAS;
                end
            end
            PH_MEAS:
            begin
                meas_next.trigger_drive = !cfg.shared_pin;
                if (active)
                begin
                    if (pulse_cur != DUR_MAX)
                    begin
                        pulse_next = pulse_cur + DURATION_BITS'(1);
                    end
                end
                else
                begin
                    last_dur_next          = pulse_cur;
                    meas_next.measure_done = 1'b1;
                    phase_next             = PH_REST;
                    step_next              = '0;
                end
            end
            PH_REST:
            begin
                meas_next.trigger_drive = !cfg.shared_pin;
                if (step_cur >= cfg.breath_ticks)
                begin
                    phase_next = first_phase;
                    step_next  = '0;
                end
                else
                begin
                    step_next = step_inc[STEP_BITS-1:0];
                end
            end
            default:
            begin
                meas_next.trigger_drive = !cfg.shared_pin;
                meas_next.phase         = PH_IDLE;
                phase_next              = PH_IDLE;
                if (cfg.enable)
                begin
                    phase_next = first_phase;
                    step_next  = '0;
                end
            end
        endcase

        meas_next.duration = last_dur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            step_reg     <= '0;
            pulse_reg    <= '0;
            last_dur_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg    <= phase_next;
                step_reg     <= step_next;
                pulse_reg    <= pulse_next;
                last_dur_reg <= last_dur_next;
            end
            if (advance)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            meas_reg <= meas_next;
        end
    end

    assign meas_valid = valid_reg;
    assign meas       = meas_reg;

endmodule

// File: sv/urc_distance.sv
// Distance stage: reciprocal multiplies for centimeters and inches, output register.
// Depends on urc_pkg.
module urc_distance (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 meas_valid,
    input  urc_pkg::urc_meas_t   meas,
    output logic                 res_valid,
    output urc_pkg::urc_result_t res
);
    import urc_pkg::*;

    logic [CM_PROD_BITS-1:0] cm_prod_next, cm_prod_reg;
    logic [IN_PROD_BITS-1:0] in_prod_next, in_prod_reg;
    urc_meas_t               meas_reg;
    logic                    valid_reg;

    assign cm_prod_next = CM_PROD_BITS'(meas.duration[DURATION_BITS-1:1]) *
                          CM_PROD_BITS'(CM_RECIP);
    assign in_prod_next = IN_PROD_BITS'(meas.duration[DURATION_BITS-1:2]) *
                          IN_PROD_BITS'(IN_RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= meas_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && meas_valid)
        begin
            meas_reg    <= meas;
            cm_prod_reg <= cm_prod_next;
            in_prod_reg <= in_prod_next;
        end
    end

    always_comb
    begin
        res.trigger_level = meas_reg.trigger_level;
        res.trigger_drive = meas_reg.trigger_drive;
        res.measure_done  = meas_reg.measure_done;
        res.duration_us   = meas_reg.duration;
        res.distance_cm   = cm_prod_reg[CM_SHIFT +: CM_BITS];
        res.distance_in   = in_prod_reg[IN_SHIFT +: IN_BITS];
        res.phase         = meas_reg.phase;
    end

    assign res_valid = valid_reg;

endmodule

// File: sv/ultrasonic_ranger_controller.sv
// Top level of the ultrasonic ranger controller: configuration registers,
// pipeline flow control and the two stages. Depends on urc_pkg, the channel
// interfaces, urc_sequencer and urc_distance.
//
// Usage: the echo channel takes one item per microsecond tick, carrying the
// sampled echo pin level. For every item accepted, exactly one item appears on
// the result channel: trigger level and drive enable for that tick, a done
// pulse when a new echo width is latched, the latched width in ticks and the
// distance in centimeters (width/58) and inches (width/148).
// Throughput is one item per clock cycle. The sequencer stage updates the phase
// and counters and registers the tick's outputs, and the distance stage multiplies
// the width by fixed reciprocals into the output register. The whole pipeline
// moves together, so when the receiver stalls the result register holds and the
// echo channel's ready drops in the same cycle; empty slots are squeezed out
// whenever the output register is free. Configuration is written through wr_en,
// wr_index and wr_data, only while no item is in flight: a rule for the user that
// the block does not enforce. After reset the block is idle and disabled, the
// active echo level is high, separate pins are used and the rest lasts 51 ticks.
module ultrasonic_ranger_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    urc_echo_if.sink                            echo,
    urc_result_if.source                        result,
    input  logic                                wr_en,
    input  logic [urc_pkg::CFG_IDX_BITS-1:0]    wr_index,
    input  logic [urc_pkg::CFG_DATA_BITS-1:0]   wr_data
);
    import urc_pkg::*;

    urc_cfg_t    cfg_reg;
    logic        advance;
    logic        meas_valid;
    urc_meas_t   meas;
    logic        res_valid;
    urc_result_t res;

    // Every register is taken from the low bits of the write data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable            <= 1'b0;
            cfg_reg.echo_active_level <= 1'b1;
            cfg_reg.shared_pin        <= 1'b0;
            cfg_reg.breath_ticks      <= BREATH_RESET;
        end
        else if (wr_en)
        begin
            unique case (cfg_index_t'(wr_index))
                REG_ENABLE:       cfg_reg.enable            <= wr_data[0];
                REG_ACTIVE_LEVEL: cfg_reg.echo_active_level <= wr_data[0];
                REG_SHARED_PIN:   cfg_reg.shared_pin        <= wr_data[0];
                REG_BREATH:       cfg_reg.breath_ticks      <= wr_data[STEP_BITS-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    // The pipeline advances whenever the output register is empty or being taken.
    assign advance    = !res_valid || result.ready;
    assign echo.ready = advance;

    urc_sequencer u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .in_valid   (echo.valid),
        .echo_level (echo.echo_level),
        .cfg        (cfg_reg),
        .meas_valid (meas_valid),
        .meas       (meas)
    );

    urc_distance u_dist (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .meas_valid (meas_valid),
        .meas       (meas),
        .res_valid  (res_valid),
        .res        (res)
    );

    assign result.valid         = res_valid;
    assign result.trigger_level = res.trigger_level;
    assign result.trigger_drive = res.trigger_drive;
    assign result.measure_done  = res.measure_done;
    assign result.duration_us   = res.duration_us;
    assign result.distance_cm   = res.distance_cm;
    assign result.distance_in   = res.distance_in;
    assign result.phase         = res.phase;

endmodule

// File: sv/urc_checker.sv
// Port-level checker for the ultrasonic ranger controller, bound to the top.
// Depends on urc_pkg and ultrasonic_ranger_controller_assert.svh.
`include "ultrasonic_ranger_controller_assert.svh"

module urc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            trigger_level,
    input logic                            trigger_drive,
    input logic                            measure_done,
    input logic [urc_pkg::DURATION_BITS-1:0] duration_us,
    input logic [urc_pkg::CM_BITS-1:0]     distance_cm,
    input logic [urc_pkg::IN_BITS-1:0]     distance_in,
    input logic [urc_pkg::PHASE_BITS-1:0]  phase
);
    import urc_pkg::*;

    // A stalled item keeps its duration.
    `URC_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(duration_us))
    // A done pulse only comes out of the measuring phase.
    `URC_ASSERT_NOW(a_done_in_meas, out_valid && measure_done, phase == PH_MEAS)
    // The trigger is high only in the trigger phase, and then it is driven.
    `URC_ASSERT_NOW(a_trig_phase, out_valid && trigger_level, phase == PH_TRIG && trigger_drive)
    // Inches never exceed centimeters for the same width.
    `URC_ASSERT_NOW(a_dist_order, out_valid, CM_BITS'(distance_in) <= distance_cm)

endmodule

bind ultrasonic_ranger_controller urc_checker u_urc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .trigger_level (result.trigger_level),
    .trigger_drive (result.trigger_drive),
    .measure_done  (result.measure_done),
    .duration_us   (result.duration_us),
    .distance_cm   (result.distance_cm),
    .distance_in   (result.distance_in),
    .phase         (result.phase)
);
